// ===== sv/gwma_pkg.sv =====
package gwma_pkg;

    localparam int WIN_SIZE = 16;
    localparam int WIN_LOG2 = $clog2(WIN_SIZE);
    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 12;
    localparam int SUM_W    = SAMPLE_W + WIN_LOG2;
    localparam int DEV_W    = SAMPLE_W + 1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(48);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [THRESH_W-1:0]        thresh_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [WIN_LOG2-1:0]        pos_t;

    typedef struct packed {
        sample_t average;
        logic    accepted;
    } result_t;

    typedef struct packed {
        logic advance;
    } step_ctrl_t;

endpackage

// ===== sv/gwma_in_if.sv =====
interface gwma_in_if
    import gwma_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== sv/gwma_out_if.sv =====
interface gwma_out_if
    import gwma_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t average;
    logic    accepted;

    modport source (output valid, output average, output accepted, input ready);
    modport sink   (input valid, input average, input accepted, output ready);
endinterface

// ===== sv/gwma_in_reg.sv =====
module gwma_in_reg
    import gwma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gwma_in_if.sink    in_ch,
    input  step_ctrl_t ctrl,
    output logic       valid,
    output sample_t    sample
);

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;

    // slot is free when empty or draining this cycle
    assign in_ch.ready = !valid_reg || ctrl.advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.advance)
        begin
            valid_next = 1'b0;
        end
        if (in_ch.valid && in_ch.ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            sample_reg <= in_ch.sample;
        end
    end

    assign valid  = valid_reg;
    assign sample = sample_reg;

endmodule

// ===== sv/gwma_datapath.sv =====
module gwma_datapath
    import gwma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_ctrl_t ctrl,
    input  sample_t    sample,
    input  logic       threshold_we,
    input  thresh_t    threshold_wdata,
    output result_t    result
);

    sample_t window_reg [WIN_SIZE];
    pos_t    pos_reg;
    pos_t    pos_next;
    sum_t    sum_reg;
    sum_t    sum_next;
    thresh_t thresh_reg;

    sample_t                  old_slot;
    sample_t                  avg_now;
    logic signed [DEV_W-1:0]  dev;
    logic [DEV_W-1:0]         dev_abs;
    logic                     take;

    assign old_slot = window_reg[pos_reg];
    // floor of sum over window by arithmetic shift
    assign avg_now  = sum_reg[SUM_W-1:WIN_LOG2];

    always_comb
    begin
        dev      = {sample[SAMPLE_W-1], sample} - {avg_now[SAMPLE_W-1], avg_now};
        dev_abs  = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
        take     = (dev_abs < {{(DEV_W-THRESH_W){1'b0}}, thresh_reg}) ||
                   (old_slot == '0);
        sum_next = sum_reg + {{WIN_LOG2{sample[SAMPLE_W-1]}}, sample}
                           - {{WIN_LOG2{old_slot[SAMPLE_W-1]}}, old_slot};
        pos_next = (pos_reg == pos_t'(WIN_SIZE - 1)) ? '0 : pos_reg + pos_t'(1);
        result.accepted = take;
        result.average  = take ? sum_next[SUM_W-1:WIN_LOG2] : avg_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_SIZE; i++)
            begin
                window_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (ctrl.advance && take)
        begin
            window_reg[pos_reg] <= sample;
            pos_reg             <= pos_next;
            sum_reg             <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (threshold_we)
        begin
            thresh_reg <= threshold_wdata;
        end
    end

endmodule

// ===== sv/gwma_out_reg.sv =====
module gwma_out_reg
    import gwma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_ctrl_t ctrl,
    input  result_t    result,
    output logic       busy,
    gwma_out_if.source out_ch
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
        if (ctrl.advance)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            result_reg <= result;
        end
    end

    // held result blocks the next step until taken
    assign busy            = valid_reg && !out_ch.ready;
    assign out_ch.valid    = valid_reg;
    assign out_ch.average  = result_reg.average;
    assign out_ch.accepted = result_reg.accepted;

endmodule

// ===== sv/gated_window_moving_average_top.sv =====
// channel    dir  payload                         handshake
// in_ch      in   sample[15:0] signed Q12.4       valid / ready
// out_ch     out  average[15:0] signed, accepted  valid / ready
// threshold  in   threshold_wdata[11:0]           threshold_we, no wait
//
// one request per cycle sustained while out_ch takes results; a request goes from input to result
// through the input register, then one pass through the window update into the result register
// rst_n clears the window, sum, position and threshold (back to 48) at once
// a held result stalls the pass; the input register still takes one request
// config writes take effect on the next request that reaches the pass
module gated_window_moving_average_top
    import gwma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gwma_in_if.sink    in_ch,
    gwma_out_if.source out_ch,
    input  logic       threshold_we,
    input  thresh_t    threshold_wdata
);

    // staged request feeding the window pass
    logic       stage_valid;
    sample_t    stage_sample;
    logic       out_busy;
    step_ctrl_t ctrl;
    result_t    result;

    // a request steps through the window whenever the result register is free
    assign ctrl.advance  = stage_valid && !out_busy;

    gwma_in_reg u_in_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .ctrl   (ctrl),
        .valid  (stage_valid),
        .sample (stage_sample)
    );

    // deviation gate, running sum and circular window
    gwma_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .sample          (stage_sample),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata),
        .result          (result)
    );

    gwma_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .result (result),
        .busy   (out_busy),
        .out_ch (out_ch)
    );

endmodule

// ===== sv/gwma_checker.sv =====
module gwma_assertions
    import gwma_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t average,
    input logic    accepted
);

    logic [2:0] pending_reg;
    sample_t    last_avg_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            last_avg_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_acc) - 3'(out_acc);
            if (out_acc)
            begin
                last_avg_reg <= average;
            end
        end
    end

    // at most the input and result registers hold requests
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more requests in flight than storage");

    // a result needs a request behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without request");

    // rejection leaves the window and so the average unchanged
    a_reject_keeps_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !accepted) |-> average == last_avg_reg)
        else $error("rejected sample moved the average");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(average) && $stable(accepted)))
        else $error("stalled result changed");

endmodule

bind gated_window_moving_average_top gwma_assertions u_gwma_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .average   (out_ch.average),
    .accepted  (out_ch.accepted)
);
